[rtl/idct_pkg.sv]
// Shared types and constants for the 8x8 inverse DCT block.
// No dependencies.
package idct_pkg;

    localparam int XW = 36;   // datapath width of the 1-D transform

    // rotation constants scaled by 2^32
    localparam longint K_INV_SQRT2 = 64'sd3037000500;
    localparam longint K_COS1      = 64'sd4212440704;
    localparam longint K_SIN1      = 64'sd837906553;
    localparam longint K_COS3      = 64'sd3571134792;
    localparam longint K_SIN3      = 64'sd2386155981;
    localparam longint K_COS6_R2   = 64'sd1162209775;
    localparam longint K_SIN6_R2   = 64'sd2805822602;

    typedef struct packed {
        logic       vld;
        logic       col;   // 1: column pass, 0: row pass
        logic [2:0] idx;   // row number or column number
    } tag_t;

    // round a 32-fraction-bit constant to cfb fraction bits
    function automatic longint kq(input longint k32, input int cfb);
        longint sh;
        sh = 64'(32 - cfb);
        return (k32 + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

endpackage

[rtl/idct_1d.sv]
// Four-stage pipelined 1-D inverse DCT (Loeffler flow graph).
// Depends on idct_pkg.
module idct_1d #(
    parameter int CONST_FRAC_BITS = 12,
    parameter int W = 36
) (
    input  logic                clk,
    input  logic                rst_n,
    input  idct_pkg::tag_t      in_tag,
    input  logic signed [W-1:0] in_d  [8],
    output idct_pkg::tag_t      out_tag,
    output logic signed [W-1:0] out_d [8]
);
    import idct_pkg::*;

    localparam int CF = CONST_FRAC_BITS;
    localparam int CW = CF + 2;
    localparam int PW = W + CW;

    localparam logic signed [CW-1:0] R2 = CW'(kq(K_INV_SQRT2, CF));
    localparam logic signed [CW-1:0] C1 = CW'(kq(K_COS1, CF));
    localparam logic signed [CW-1:0] S1 = CW'(kq(K_SIN1, CF));
    localparam logic signed [CW-1:0] C3 = CW'(kq(K_COS3, CF));
    localparam logic signed [CW-1:0] S3 = CW'(kq(K_SIN3, CF));
    localparam logic signed [CW-1:0] C6 = CW'(kq(K_COS6_R2, CF));
    localparam logic signed [CW-1:0] S6 = CW'(kq(K_SIN6_R2, CF));

    function automatic logic signed [W-1:0] hs(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
        logic signed [W:0] t;
        t = {a[W-1], a} + {b[W-1], b} + (W+1)'(1);
        return t[W:1];
    endfunction

    function automatic logic signed [W-1:0] hd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
        logic signed [W:0] t;
        t = {a[W-1], a} - {b[W-1], b} + (W+1)'(1);
        return t[W:1];
    endfunction

    function automatic logic signed [W-1:0] fxr(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + (PW'(1) <<< (CF - 1));
        t = t >>> CF;
        return t[W-1:0];
    endfunction

    function automatic logic signed [PW-1:0] mul(input logic signed [W-1:0] a,
                                                 input logic signed [CW-1:0] c);
        logic signed [PW-1:0] ae;
        logic signed [PW-1:0] ce;
        ae = PW'(a);
        ce = PW'(c);
        return ae * ce;
    endfunction

    tag_t t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [W-1:0] s1_reg [8];
    logic signed [W-1:0] s2_reg [8];
    logic signed [W-1:0] s3_reg [8];
    logic signed [W-1:0] s4_reg [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
        end
        else
        begin
            t1_reg <= in_tag;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: odd-input butterflies and root-two scaling
        s1_reg[0] <= in_d[0];
        s1_reg[1] <= in_d[4];
        s1_reg[2] <= in_d[2];
        s1_reg[3] <= in_d[6];
        s1_reg[4] <= hd(in_d[1], in_d[7]);
        s1_reg[5] <= fxr(mul(in_d[3], R2));
        s1_reg[6] <= fxr(mul(in_d[5], R2));
        s1_reg[7] <= hs(in_d[1], in_d[7]);
        // stage 2: even and odd butterflies and 6pi/16 rotation
        s2_reg[0] <= hs(s1_reg[0], s1_reg[1]);
        s2_reg[1] <= hd(s1_reg[0], s1_reg[1]);
        s2_reg[2] <= fxr(mul(s1_reg[2], C6) - mul(s1_reg[3], S6));
        s2_reg[3] <= fxr(mul(s1_reg[3], C6) + mul(s1_reg[2], S6));
        s2_reg[4] <= hs(s1_reg[4], s1_reg[6]);
        s2_reg[5] <= hd(s1_reg[7], s1_reg[5]);
        s2_reg[6] <= hd(s1_reg[4], s1_reg[6]);
        s2_reg[7] <= hs(s1_reg[7], s1_reg[5]);
        // stage 3: even butterfly, 3pi/16 and pi/16 rotations
        s3_reg[0] <= hs(s2_reg[0], s2_reg[3]);
        s3_reg[1] <= hs(s2_reg[1], s2_reg[2]);
        s3_reg[2] <= hd(s2_reg[1], s2_reg[2]);
        s3_reg[3] <= hd(s2_reg[0], s2_reg[3]);
        s3_reg[4] <= fxr(mul(s2_reg[4], C3) - mul(s2_reg[7], S3));
        s3_reg[7] <= fxr(mul(s2_reg[7], C3) + mul(s2_reg[4], S3));
        s3_reg[5] <= fxr(mul(s2_reg[5], C1) - mul(s2_reg[6], S1));
        s3_reg[6] <= fxr(mul(s2_reg[6], C1) + mul(s2_reg[5], S1));
        // stage 4: output butterflies
        s4_reg[0] <= hs(s3_reg[0], s3_reg[7]);
        s4_reg[1] <= hs(s3_reg[1], s3_reg[6]);
        s4_reg[2] <= hs(s3_reg[2], s3_reg[5]);
        s4_reg[3] <= hs(s3_reg[3], s3_reg[4]);
        s4_reg[4] <= hd(s3_reg[3], s3_reg[4]);
        s4_reg[5] <= hd(s3_reg[2], s3_reg[5]);
        s4_reg[6] <= hd(s3_reg[1], s3_reg[6]);
        s4_reg[7] <= hd(s3_reg[0], s3_reg[7]);
    end

    assign out_tag = t4_reg;
    assign out_d   = s4_reg;

endmodule

[rtl/idct_8x8_pixel_block_core.sv]
// Top level of the 8x8 inverse DCT: row pass, skewed transpose store,
// column pass, pixel buffer. Depends on idct_pkg and idct_1d.
//
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | coef_0..coef_7, one coefficient row per beat
//  output  | out_valid/ out_ready | pixel_0..pixel_7, last_row, one pixel row per beat
//
// Rows enter the shared 4-stage 1-D transform at one per cycle while in_ready is
// high. After the eighth row is written back, the column pass reads one column a
// cycle from the 8-bank store; input holds off from the eighth row's beat until
// the last column read has entered the transform.
// Output rows drain from the pixel buffer while the next block's rows enter;
// a column pass waits until the buffer is empty. Reset empties all control.
module idct_8x8_pixel_block_core #(
    parameter int CONST_FRAC_BITS = 12,
    parameter int DATA_FRAC_BITS  = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] coef_0,
    input  logic signed [15:0] coef_1,
    input  logic signed [15:0] coef_2,
    input  logic signed [15:0] coef_3,
    input  logic signed [15:0] coef_4,
    input  logic signed [15:0] coef_5,
    input  logic signed [15:0] coef_6,
    input  logic signed [15:0] coef_7,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         pixel_0,
    output logic [7:0]         pixel_1,
    output logic [7:0]         pixel_2,
    output logic [7:0]         pixel_3,
    output logic [7:0]         pixel_4,
    output logic [7:0]         pixel_5,
    output logic [7:0]         pixel_6,
    output logic [7:0]         pixel_7,
    output logic               last_row
);
    import idct_pkg::*;

    localparam int D  = DATA_FRAC_BITS;
    localparam int TW = XW + 5;
    localparam int SW = D + 20;     // row results stay below 2^(D+18)

    function automatic logic [7:0] to_pix(input logic signed [XW-1:0] v);
        logic signed [TW-1:0] t;
        logic signed [TW-1:0] top;
        top = TW'(255) <<< D;
        t = {{2{v[XW-1]}}, v, 3'b000} + (TW'(128) <<< D);
        if (t < 0)
            t = '0;
        else if (t > top)
            t = top;
        t = t + (TW'(1) <<< (D - 1));
        return t[D+7:D];
    endfunction

    logic signed [15:0] coef [8];
    assign coef = '{coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6, coef_7};

    logic [2:0] rows_reg;
    logic       blk_pend_reg;
    logic       col_wait_reg;
    logic       col_act_reg;
    logic [2:0] col_x_reg;
    logic       rd_vld_reg;
    logic [2:0] rd_x_reg;
    logic       ofull_reg;
    logic [2:0] orow_reg;

    logic [SW-1:0] mem [8][8];      // [bank][row], column x of row r in bank x+r
    logic [SW-1:0] rd_reg [8];
    logic [7:0]    obuf [8][8];     // [row][column]

    logic in_acc, out_acc;
    tag_t xf_in_tag, xf_out_tag;
    logic signed [XW-1:0] xf_in  [8];
    logic signed [XW-1:0] xf_out [8];

    assign in_ready = !blk_pend_reg && !rd_vld_reg;
    assign in_acc   = in_valid && in_ready;
    assign out_valid = ofull_reg;
    assign out_acc  = out_valid && out_ready;

    always_comb
    begin
        xf_in_tag.vld = in_acc || rd_vld_reg;
        xf_in_tag.col = rd_vld_reg;
        xf_in_tag.idx = rd_vld_reg ? rd_x_reg : rows_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (rd_vld_reg)
                xf_in[i] = XW'($signed(rd_reg[3'(i) + rd_x_reg]));
            else
                xf_in[i] = XW'($signed({coef[i], {D{1'b0}}}));
        end
    end

    idct_1d #(
        .CONST_FRAC_BITS(CONST_FRAC_BITS),
        .W(XW)
    ) u_xf (
        .clk(clk),
        .rst_n(rst_n),
        .in_tag(xf_in_tag),
        .in_d(xf_in),
        .out_tag(xf_out_tag),
        .out_d(xf_out)
    );

    // store write-back of row results, column reads and pixel buffer writes
    always_ff @(posedge clk)
    begin
        if (xf_out_tag.vld && !xf_out_tag.col)
        begin
            for (int x = 0; x < 8; x++)
                mem[3'(x) + xf_out_tag.idx][xf_out_tag.idx] <= xf_out[x][SW-1:0];
        end
        if (col_act_reg)
        begin
            for (int b = 0; b < 8; b++)
                rd_reg[b] <= mem[b][3'(b) - col_x_reg];
        end
        if (xf_out_tag.vld && xf_out_tag.col)
        begin
            for (int y = 0; y < 8; y++)
                obuf[y][xf_out_tag.idx] <= to_pix(xf_out[y]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= '0;
            blk_pend_reg <= 1'b0;
            col_wait_reg <= 1'b0;
            col_act_reg  <= 1'b0;
            col_x_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            rd_x_reg     <= '0;
            ofull_reg    <= 1'b0;
            orow_reg     <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                rows_reg <= rows_reg + 3'd1;
                if (rows_reg == 3'd7)
                    blk_pend_reg <= 1'b1;
            end

            if (xf_out_tag.vld && !xf_out_tag.col && xf_out_tag.idx == 3'd7)
                col_wait_reg <= 1'b1;
            else if (col_wait_reg && !ofull_reg && !col_act_reg)
            begin
                col_wait_reg <= 1'b0;
                col_act_reg  <= 1'b1;
                col_x_reg    <= '0;
            end

            rd_vld_reg <= col_act_reg;
            if (col_act_reg)
            begin
                rd_x_reg  <= col_x_reg;
                col_x_reg <= col_x_reg + 3'd1;
                if (col_x_reg == 3'd7)
                begin
                    col_act_reg  <= 1'b0;
                    blk_pend_reg <= 1'b0;
                end
            end

            if (xf_out_tag.vld && xf_out_tag.col && xf_out_tag.idx == 3'd7)
            begin
                ofull_reg <= 1'b1;
                orow_reg  <= '0;
            end
            else if (out_acc)
            begin
                orow_reg <= orow_reg + 3'd1;
                if (orow_reg == 3'd7)
                    ofull_reg <= 1'b0;
            end
        end
    end

    assign pixel_0  = obuf[orow_reg][0];
    assign pixel_1  = obuf[orow_reg][1];
    assign pixel_2  = obuf[orow_reg][2];
    assign pixel_3  = obuf[orow_reg][3];
    assign pixel_4  = obuf[orow_reg][4];
    assign pixel_5  = obuf[orow_reg][5];
    assign pixel_6  = obuf[orow_reg][6];
    assign pixel_7  = obuf[orow_reg][7];
    assign last_row = (orow_reg == 3'd7);

endmodule

[bench/tb.sv]
// Self-checking bench for idct_8x8_pixel_block_core: coefficient rows in,
// predicted pixel rows compared beat by beat. Depends on the RTL only.
module tb;

    localparam int CFB = 12;
    localparam int DFB = 8;
    localparam int N_RANDOM = 160;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [7:0] px[8];
        logic       last;
    } pix_row_t;

    typedef struct {
        logic signed [15:0] c[8];
    } coef_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] coef[8];
    logic out_valid;
    logic out_ready;
    logic [7:0] pixel[8];
    logic last_row;

    pix_row_t   pix_expected[$];
    coef_row_t  row_plan[$];
    longint     transpose_buf[8][8];
    int         row_cnt;
    int         err_cnt;
    int         idle_cycles;
    bit         hold_off;
    bit         stim_done;

    idct_8x8_pixel_block_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .coef_0(coef[0]), .coef_1(coef[1]), .coef_2(coef[2]), .coef_3(coef[3]),
        .coef_4(coef[4]), .coef_5(coef[5]), .coef_6(coef[6]), .coef_7(coef[7]),
        .out_valid(out_valid), .out_ready(out_ready),
        .pixel_0(pixel[0]), .pixel_1(pixel[1]), .pixel_2(pixel[2]),
        .pixel_3(pixel[3]), .pixel_4(pixel[4]), .pixel_5(pixel[5]),
        .pixel_6(pixel[6]), .pixel_7(pixel[7]),
        .last_row(last_row)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic longint round_const(longint k32);
        return (k32 + (64'sd1 <<< (31 - CFB))) >>> (32 - CFB);
    endfunction

    function automatic longint half_add(longint a, longint b);
        return (a + b + 1) >>> 1;
    endfunction

    function automatic longint half_sub(longint a, longint b);
        return (a - b + 1) >>> 1;
    endfunction

    function automatic longint fx_round(longint p);
        return (p + (64'sd1 <<< (CFB - 1))) >>> CFB;
    endfunction

    task automatic idct_1d(input longint v[8], output longint o[8]);
        longint a[8];
        longint b[8];
        longint r2, c6, s6, c3, s3, c1, s1;
        r2 = round_const(64'sd3037000500);
        c1 = round_const(64'sd4212440704);
        s1 = round_const(64'sd837906553);
        c3 = round_const(64'sd3571134792);
        s3 = round_const(64'sd2386155981);
        c6 = round_const(64'sd1162209775);
        s6 = round_const(64'sd2805822602);
        a[0] = v[0]; a[1] = v[4]; a[2] = v[2]; a[3] = v[6];
        a[4] = half_sub(v[1], v[7]);
        a[5] = fx_round(v[3] * r2);
        a[6] = fx_round(v[5] * r2);
        a[7] = half_add(v[1], v[7]);
        b[0] = half_add(a[0], a[1]);
        b[1] = half_sub(a[0], a[1]);
        b[2] = fx_round(a[2] * c6 - a[3] * s6);
        b[3] = fx_round(a[3] * c6 + a[2] * s6);
        b[4] = half_add(a[4], a[6]);
        b[5] = half_sub(a[7], a[5]);
        b[6] = half_sub(a[4], a[6]);
        b[7] = half_add(a[7], a[5]);
        a[0] = half_add(b[0], b[3]);
        a[1] = half_add(b[1], b[2]);
        a[2] = half_sub(b[1], b[2]);
        a[3] = half_sub(b[0], b[3]);
        a[4] = fx_round(b[4] * c3 - b[7] * s3);
        a[7] = fx_round(b[7] * c3 + b[4] * s3);
        a[5] = fx_round(b[5] * c1 - b[6] * s1);
        a[6] = fx_round(b[6] * c1 + b[5] * s1);
        o[0] = half_add(a[0], a[7]);
        o[1] = half_add(a[1], a[6]);
        o[2] = half_add(a[2], a[5]);
        o[3] = half_add(a[3], a[4]);
        o[4] = half_sub(a[3], a[4]);
        o[5] = half_sub(a[2], a[5]);
        o[6] = half_sub(a[1], a[6]);
        o[7] = half_sub(a[0], a[7]);
    endtask

    function automatic logic [7:0] level_shift(longint v);
        longint t;
        t = v * 8 + (64'sd128 <<< DFB);
        if (t < 0)
            t = 0;
        if (t > (64'sd255 <<< DFB))
            t = 64'sd255 <<< DFB;
        return 8'((t + (64'sd1 <<< (DFB - 1))) >>> DFB);
    endfunction

    // row accepted: run row pass, on the eighth row queue the eight pixel rows
    task automatic predict_row(input coef_row_t r);
        longint line[8];
        longint res[8];
        pix_row_t blk[8];
        for (int i = 0; i < 8; i++)
            line[i] = longint'(r.c[i]) <<< DFB;
        idct_1d(line, res);
        transpose_buf[row_cnt] = res;
        if (row_cnt == 7)
        begin
            for (int x = 0; x < 8; x++)
            begin
                for (int i = 0; i < 8; i++)
                    line[i] = transpose_buf[i][x];
                idct_1d(line, res);
                for (int y = 0; y < 8; y++)
                    blk[y].px[x] = level_shift(res[y]);
            end
            for (int y = 0; y < 8; y++)
            begin
                blk[y].last = (y == 7);
                pix_expected.push_back(blk[y]);
            end
        end
        row_cnt = (row_cnt + 1) % 8;
    endtask

    // ---------------- stimulus plan ----------------
    function automatic coef_row_t fill_row(logic signed [15:0] v);
        coef_row_t r;
        for (int i = 0; i < 8; i++)
            r.c[i] = v;
        return r;
    endfunction

    function automatic coef_row_t rand_row();
        coef_row_t r;
        int mode;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 8; i++)
        begin
            case (mode)
                0: r.c[i] = 16'($urandom);
                1: r.c[i] = 16'($urandom_range(0, 64)) - 16'sd32;
                2: r.c[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'sd0;
                default: r.c[i] = 16'($urandom_range(0, 2048)) - 16'sd1024;
            endcase
        end
        return r;
    endfunction

    // directed table: all zero (flat 128), max DC, full extremes, then random rows
    initial
    begin
        coef_row_t r;
        for (int i = 0; i < 8; i++)
            row_plan.push_back(fill_row(16'sd0));
        for (int i = 0; i < 8; i++)
        begin
            r = fill_row(16'sd0);
            if (i == 0)
                r.c[0] = 16'sh7fff;
            row_plan.push_back(r);
        end
        for (int i = 0; i < 8; i++)
            row_plan.push_back(fill_row((i % 2) ? 16'sh8000 : 16'sh7fff));
        for (int i = 0; i < N_RANDOM; i++)
            row_plan.push_back(rand_row());
    end

    // directed rows with an at-a-glance answer: zero block and max-DC block
    task automatic check_known(input int rowno, input pix_row_t got);
        logic [7:0] want;
        if (rowno < 8)
            want = 8'd128;
        else if (rowno < 16)
            want = 8'd255;
        else
            return;
        for (int i = 0; i < 8; i++)
            if (got.px[i] !== want)
            begin
                $error("pixel_%0d (table): expected %0d got %0d", i, want, got.px[i]);
                err_cnt++;
            end
    endtask

    // ---------------- drivers ----------------
    initial
    begin
        rst_n = 0;
        in_valid = 0;
        for (int i = 0; i < 8; i++)
            coef[i] <= '0;
        stim_done = 0;
        row_cnt = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        for (int n = 0; n < row_plan.size(); n++)
        begin
            int gap;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) :
                  ((n >= 64 && n < 96) ? 0 : $urandom_range(0, 2));
            if (gap > 0)
            begin
                in_valid <= 0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1;
            for (int i = 0; i < 8; i++)
                coef[i] <= row_plan[n].c[i];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_row(row_plan[n]);
        end
        in_valid <= 0;
        stim_done = 1;
    end

    initial
    begin
        int rowno;
        pix_row_t got, want;
        out_ready = 0;
        hold_off = 0;
        rowno = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                for (int i = 0; i < 8; i++)
                    got.px[i] = pixel[i];
                got.last = last_row;
                check_known(rowno, got);
                if (pix_expected.size() == 0)
                begin
                    $error("unexpected pixel row beat");
                    err_cnt++;
                end
                else
                begin
                    want = pix_expected.pop_front();
                    for (int i = 0; i < 8; i++)
                        if (got.px[i] !== want.px[i])
                        begin
                            $error("pixel_%0d: expected %0d got %0d", i, want.px[i],
                                   got.px[i]);
                            err_cnt++;
                        end
                    if (got.last !== want.last)
                    begin
                        $error("last_row: expected %0d got %0d", want.last, got.last);
                        err_cnt++;
                    end
                end
                rowno++;
            end
            // long hold-off while the sender keeps pushing
            if (rowno == 40 && !hold_off)
            begin
                hold_off = 1;
                out_ready <= 0;
                for (int k = 0; k < 150; k++)
                    @(posedge clk);
                out_ready <= 1;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
                out_ready <= 1;
            end
            else if ($urandom_range(0, 3) == 0)
                out_ready <= ($urandom_range(0, 7) == 0) ? 1'b0 : ~out_ready;
            else
                out_ready <= 1;
        end
    end

    // ---------------- watchdog and end ----------------
    initial
    begin
        err_cnt = 0;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (stim_done && pix_expected.size() == 0)
            begin
                repeat (40) @(posedge clk);
                if (err_cnt == 0 && pix_expected.size() == 0)
                    $display("Testbench completed without errors");
                else
                    $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
